>>> design/lst_pkg.sv
// lst_pkg: shared types and constants for the indexed list store.
// Used by lst_cell, lst_read and indexed_list_store; no dependencies.
package lst_pkg;

   // Default sizing
   localparam int LST_CAPACITY   = 64;
   localparam int LST_DATA_WIDTH = 32;

   // Fixed port widths
   localparam int KIND_W    = 3;
   localparam int POS_W     = 8;
   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int RSP_CNT_W = 7;

   // Read path: cells are gathered in groups of this size
   localparam int READ_GROUP_BITS = 5;
   localparam int READ_GROUP      = 1 << READ_GROUP_BITS;

   typedef enum logic [KIND_W-1:0] {
      K_GET          = 3'd0,
      K_SET          = 3'd1,
      K_INSERT       = 3'd2,
      K_REMOVE       = 3'd3,
      K_ADD_FIRST    = 3'd4,
      K_ADD_LAST     = 3'd5,
      K_REMOVE_FIRST = 3'd6,
      K_REMOVE_LAST  = 3'd7
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // What the cell row does in the update cycle
   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_SET  = 2'd1,
      OP_INS  = 2'd2,
      OP_REM  = 2'd3
   } op_type;

   typedef struct packed {
      logic   fire;
      op_type op;
   } cell_ctl_type;

endpackage

>>> design/lst_cell.sv
// lst_cell: one element slot of the list, shifting with its neighbors.
// Depends on lst_pkg.
module lst_cell import lst_pkg::*; #(
   parameter int DATA_WIDTH = LST_DATA_WIDTH,
   parameter int IDX_W      = 6,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic [IDX_W-1:0]      cmd_idx,
   input  logic [DATA_WIDTH-1:0] cmd_data,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   output logic [DATA_WIDTH-1:0] data
);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  at_me, after_me;

   assign at_me    = (cmd_idx == IDX_W'(INDEX));
   assign after_me = (cmd_idx < IDX_W'(INDEX));

   // Next value: write here, take from the lower slot, or from the upper slot
   always_comb begin
      data_in = data_ff;
      if (ctl.fire) begin
         case (ctl.op)
            OP_SET: begin
               if (at_me) data_in = cmd_data;
            end
            OP_INS: begin
               if (at_me)         data_in = cmd_data;
               else if (after_me) data_in = left_data;
            end
            OP_REM: begin
               if (at_me || after_me) data_in = right_data;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> design/lst_read.sv
// lst_read: two-level read select over the cell row, group stage registered.
// Depends on lst_pkg.
module lst_read import lst_pkg::*; #(
   parameter int CAPACITY   = LST_CAPACITY,
   parameter int DATA_WIDTH = LST_DATA_WIDTH,
   parameter int IDX_W      = 6
) (
   input  logic                  clock,
   input  logic [IDX_W-1:0]      idx,
   input  logic [DATA_WIDTH-1:0] cell_data [CAPACITY],
   output logic [DATA_WIDTH-1:0] read_data
);

   localparam int NUM_GROUPS = (CAPACITY + READ_GROUP - 1) / READ_GROUP;

   logic [DATA_WIDTH-1:0] group_ff [NUM_GROUPS];
   logic [DATA_WIDTH-1:0] group_in [NUM_GROUPS];

   // First level: pick the indexed word inside each group
   always_comb begin
      int k;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < READ_GROUP; j++) begin
            k = g * READ_GROUP + j;
            if (k < CAPACITY && int'(idx) == k) group_in[g] = cell_data[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   // Second level: pick the group
   always_comb begin
      read_data = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         if ((int'(idx) >> READ_GROUP_BITS) == g) read_data = group_ff[g];
      end
   end

endmodule

>>> design/indexed_list_store.sv
// indexed_list_store: ordered list of up to CAPACITY words in a row of shift cells.
// Sequence: the request is decoded when accepted, then group read, then update; the
// result is held until taken. The next item is taken only after the result handshake.
// The read select is split in two levels with the group stage registered.
// Reset: synchronous, clears the element count and control; cell contents are not
// cleared, only positions below the count are ever read.
module indexed_list_store import lst_pkg::*; #(
   parameter int CAPACITY   = LST_CAPACITY,
   parameter int DATA_WIDTH = LST_DATA_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [POS_W-1:0]     req_position,
   input  logic [VALUE_W-1:0]   req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VALUE_W-1:0]   rsp_read_value,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [RSP_CNT_W-1:0] rsp_element_count
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_GATHER = 4'b0010,
      S_APPLY  = 4'b0100,
      S_RESP   = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   op_type                op_ff, op_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] value_ff;
   status_type            status_ff, status_in;
   logic                  rd_en_ff, rd_en_in;
   logic [VALUE_W-1:0]    rsp_value_ff;
   status_type            rsp_status_ff;
   logic [RSP_CNT_W-1:0]  rsp_count_ff;

   logic [CMP_W-1:0]      pos_x, cnt_x;
   logic [CNT_W-1:0]      cnt_m1;
   logic                  full;
   logic [EXT_W-1:0]      value_ext, read_ext;
   logic [DATA_WIDTH-1:0] read_data;
   logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
   logic [DATA_WIDTH-1:0] left_data  [CAPACITY];
   logic [DATA_WIDTH-1:0] right_data [CAPACITY];
   cell_ctl_type          ctl;
   logic                  accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign pos_x     = CMP_W'(req_position);
   assign cnt_x     = CMP_W'(count_ff);
   assign cnt_m1    = count_ff - CNT_W'(1);
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign value_ext = EXT_W'(req_value);

   // Decode the request against the current count
   always_comb begin
      op_in     = OP_NONE;
      idx_in    = '0;
      status_in = ST_OK;
      rd_en_in  = 1'b0;
      case (kind_type'(req_kind))
         K_GET: begin
            if (pos_x < cnt_x) begin
               idx_in   = pos_x[IDX_W-1:0];
               rd_en_in = 1'b1;
            end else status_in = ST_MISS;
         end
         K_SET: begin
            if (pos_x < cnt_x) begin
               op_in  = OP_SET;
               idx_in = pos_x[IDX_W-1:0];
            end else status_in = ST_MISS;
         end
         K_INSERT: begin
            if (pos_x > cnt_x) status_in = ST_MISS;
            else if (full)     status_in = ST_FULL;
            else begin
               op_in  = OP_INS;
               idx_in = pos_x[IDX_W-1:0];
            end
         end
         K_REMOVE: begin
            if (pos_x < cnt_x) begin
               op_in    = OP_REM;
               idx_in   = pos_x[IDX_W-1:0];
               rd_en_in = 1'b1;
            end else status_in = ST_MISS;
         end
         K_ADD_FIRST: begin
            if (full) status_in = ST_FULL;
            else op_in = OP_INS;
         end
         K_ADD_LAST: begin
            if (full) status_in = ST_FULL;
            else begin
               op_in  = OP_INS;
               idx_in = count_ff[IDX_W-1:0];
            end
         end
         K_REMOVE_FIRST: begin
            if (count_ff != '0) begin
               op_in    = OP_REM;
               rd_en_in = 1'b1;
            end else status_in = ST_MISS;
         end
         K_REMOVE_LAST: begin
            if (count_ff != '0) begin
               op_in    = OP_REM;
               idx_in   = cnt_m1[IDX_W-1:0];
               rd_en_in = 1'b1;
            end else status_in = ST_MISS;
         end
         default: status_in = ST_MISS;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (accept) state_in = S_GATHER;
         S_GATHER: state_in = S_APPLY;
         S_APPLY:  state_in = S_RESP;
         S_RESP:   if (rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Count moves in the update cycle
   always_comb begin
      count_in = count_ff;
      if (state_ff == S_APPLY) begin
         case (op_ff)
            OP_INS:  count_in = count_ff + CNT_W'(1);
            OP_REM:  count_in = count_ff - CNT_W'(1);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Item registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= op_in;
         idx_ff    <= idx_in;
         value_ff  <= value_ext[DATA_WIDTH-1:0];
         status_ff <= status_in;
         rd_en_ff  <= rd_en_in;
      end
   end

   // Result register
   assign read_ext = EXT_W'(read_data);
   always_ff @(posedge clock) begin
      if (state_ff == S_APPLY) begin
         rsp_value_ff  <= rd_en_ff ? read_ext[VALUE_W-1:0] : '0;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= RSP_CNT_W'(count_in);
      end
   end

   assign rsp_valid         = (state_ff == S_RESP);
   assign rsp_read_value    = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_count = rsp_count_ff;

   // Cell row
   assign ctl.fire = (state_ff == S_APPLY);
   assign ctl.op   = op_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_data[i] = '0;
      end else begin : g_left
         assign left_data[i] = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data[i] = '0;
      end else begin : g_right
         assign right_data[i] = cell_data[i+1];
      end

      lst_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .IDX_W      (IDX_W),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cmd_idx    (idx_ff),
         .cmd_data   (value_ff),
         .left_data  (left_data[i]),
         .right_data (right_data[i]),
         .data       (cell_data[i])
      );
   end

   lst_read #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W)
   ) u_read (
      .clock      (clock),
      .idx        (idx_ff),
      .cell_data  (cell_data),
      .read_data  (read_data)
   );

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 (state_ff == S_APPLY) ##1 rsp_valid)
      else $error("result not presented three cycles after accept");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> rsp_element_count == RSP_CNT_W'(CAPACITY))
      else $error("full status with list not full");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("new item taken while result pending");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_APPLY) |=> $stable(count_ff))
      else $error("count moved outside the update cycle");

endmodule
